[hdl/spu_pkg.sv]
// Shared types and character constants for the serial mode string parser.
package spu_pkg;

  // Characters the parser recognizes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_FOUR  = 8'h34;
  localparam logic [7:0] CH_FIVE  = 8'h35;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_O     = 8'h6F;

  // Baud codes
  localparam logic [2:0] BAUD_110  = 3'd0;
  localparam logic [2:0] BAUD_150  = 3'd1;
  localparam logic [2:0] BAUD_300  = 3'd2;
  localparam logic [2:0] BAUD_600  = 3'd3;
  localparam logic [2:0] BAUD_1200 = 3'd4;
  localparam logic [2:0] BAUD_2400 = 3'd5;
  localparam logic [2:0] BAUD_4800 = 3'd6;
  localparam logic [2:0] BAUD_9600 = 3'd7;

  // Parity codes
  localparam logic [1:0] PAR_NONE = 2'd0;
  localparam logic [1:0] PAR_EVEN = 2'd1;
  localparam logic [1:0] PAR_ODD  = 2'd2;

  // Field positions in the mode string
  localparam logic [2:0] FLD_BAUD   = 3'd0;
  localparam logic [2:0] FLD_DATA   = 3'd1;
  localparam logic [2:0] FLD_PARITY = 3'd2;
  localparam logic [2:0] FLD_STOP   = 3'd3;
  localparam logic [2:0] FLD_REST   = 3'd4;

  // Result defaults
  localparam logic [3:0] DATA_BASE = 4'd5;
  localparam logic [1:0] STOP_ONE  = 2'd1;
  localparam logic [1:0] STOP_TWO  = 2'd2;

  // Bytes seen in a field saturate here
  localparam logic [1:0] CIF_MAX = 2'd2;

  typedef enum logic [1:0] {
    TK_CHAR,
    TK_COMMA,
    TK_END
  } tok_kind_t;

  // Classified byte passed from front to back
  typedef struct packed {
    tok_kind_t  kind;
    logic       is_one;
    logic       baud1_ok;
    logic [2:0] baud1_code;
    logic       baud2_ok;
    logic [2:0] baud2_code;
    logic       data_ok;
    logic [1:0] data_code;
    logic       par_ok;
    logic [1:0] par_code;
    logic       port;
    logic       last;
  } spu_tok_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       port_num;
    logic       last_char;
  } spu_in_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] baud_code;
    logic [3:0] data_bits;
    logic [1:0] parity_code;
    logic [1:0] stop_bits;
    logic       port_out;
  } spu_out_t;

endpackage

[hdl/spu_chan_if.sv]
// Valid/ready channel carrying one payload per request.
interface spu_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hdl/spu_front.sv]
// Front end: accepts mode string bytes and classifies them into tokens.
module spu_front (
  spu_chan_if.sink          in_ch,
  input  logic              full,
  output logic              push,
  output spu_pkg::spu_tok_t tok
);

  logic [7:0] c;
  logic [7:0] data_diff;

  assign c         = in_ch.payload.char_in;
  assign data_diff = c - spu_pkg::CH_FIVE;

  // Take a request whenever the queue has room
  assign in_ch.ready = !full;
  assign push        = in_ch.valid && !full;

  // Classify the byte
  always_comb begin
    tok = '0;
    if (c == spu_pkg::CH_NUL) begin
      tok.kind = spu_pkg::TK_END;
    end else if (c == spu_pkg::CH_COMMA) begin
      tok.kind = spu_pkg::TK_COMMA;
    end else begin
      tok.kind = spu_pkg::TK_CHAR;
    end
    tok.is_one = (c == spu_pkg::CH_ONE);

    // First baud character
    tok.baud1_ok = 1'b1;
    case (c)
      spu_pkg::CH_TWO:   tok.baud1_code = spu_pkg::BAUD_2400;
      spu_pkg::CH_THREE: tok.baud1_code = spu_pkg::BAUD_300;
      spu_pkg::CH_FOUR:  tok.baud1_code = spu_pkg::BAUD_4800;
      spu_pkg::CH_SIX:   tok.baud1_code = spu_pkg::BAUD_600;
      spu_pkg::CH_NINE:  tok.baud1_code = spu_pkg::BAUD_9600;
      default: begin
        tok.baud1_ok   = 1'b0;
        tok.baud1_code = spu_pkg::BAUD_110;
      end
    endcase

    // Second baud character after a leading one
    tok.baud2_ok = 1'b1;
    case (c)
      spu_pkg::CH_ONE:  tok.baud2_code = spu_pkg::BAUD_110;
      spu_pkg::CH_FIVE: tok.baud2_code = spu_pkg::BAUD_150;
      spu_pkg::CH_TWO:  tok.baud2_code = spu_pkg::BAUD_1200;
      default: begin
        tok.baud2_ok   = 1'b0;
        tok.baud2_code = spu_pkg::BAUD_110;
      end
    endcase

    // Data bits five through eight
    tok.data_ok   = (c >= spu_pkg::CH_FIVE) && (c <= spu_pkg::CH_EIGHT);
    tok.data_code = data_diff[1:0];

    // Parity letter
    tok.par_ok = 1'b1;
    if (c == spu_pkg::CH_N) begin
      tok.par_code = spu_pkg::PAR_NONE;
    end else if (c == spu_pkg::CH_E) begin
      tok.par_code = spu_pkg::PAR_EVEN;
    end else if (c == spu_pkg::CH_O) begin
      tok.par_code = spu_pkg::PAR_ODD;
    end else begin
      tok.par_ok   = 1'b0;
      tok.par_code = spu_pkg::PAR_NONE;
    end

    tok.port = in_ch.payload.port_num;
    tok.last = in_ch.payload.last_char;
  end

endmodule

[hdl/spu_queue.sv]
// Token queue between the front end and the back end.
module spu_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  spu_pkg::spu_tok_t push_tok,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output spu_pkg::spu_tok_t head_tok
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  spu_pkg::spu_tok_t   entries [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;
  logic                do_pop;

  assign full       = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head_tok   = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  // Store tokens
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_tok;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hdl/spu_back.sv]
// Back end: applies tokens to the field state and registers the result.
module spu_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  spu_pkg::spu_tok_t head_tok,
  output logic              pop,
  spu_chan_if.source        out_ch
);

  logic [2:0] field_index, field_index_next;
  logic [1:0] char_in_field, char_in_field_next;
  logic       baud_first, baud_first_next;
  logic [2:0] baud_reg, baud_reg_next;
  logic [1:0] data_reg, data_reg_next;
  logic [1:0] parity_reg, parity_reg_next;
  logic       stop_reg, stop_reg_next;
  logic       error_flag, error_flag_next;
  logic       string_ended, string_ended_next;

  logic             out_valid;
  spu_pkg::spu_out_t out_data;
  spu_pkg::spu_out_t result;
  logic             good;

  // Drain tokens; a last token waits only for a free output register
  assign pop = head_valid && (!head_tok.last || !out_valid || out_ch.ready);

  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_data;

  // Field state update for one token
  always_comb begin
    field_index_next   = field_index;
    char_in_field_next = char_in_field;
    baud_first_next    = baud_first;
    baud_reg_next      = baud_reg;
    data_reg_next      = data_reg;
    parity_reg_next    = parity_reg;
    stop_reg_next      = stop_reg;
    error_flag_next    = error_flag;
    string_ended_next  = string_ended;

    if (!string_ended) begin
      case (head_tok.kind)
        spu_pkg::TK_END: begin
          string_ended_next = 1'b1;
        end
        spu_pkg::TK_COMMA: begin
          // Close the current field
          if (field_index == spu_pkg::FLD_BAUD) begin
            if (char_in_field == 2'd0 || (char_in_field == 2'd1 && baud_first)) begin
              error_flag_next = 1'b1;
            end
          end else if (field_index == spu_pkg::FLD_DATA ||
                       field_index == spu_pkg::FLD_PARITY) begin
            if (char_in_field == 2'd0) begin
              error_flag_next = 1'b1;
            end
          end else if (field_index == spu_pkg::FLD_STOP) begin
            if (char_in_field == 2'd0) begin
              stop_reg_next = 1'b1;
            end
          end
          if (field_index < spu_pkg::FLD_REST) begin
            field_index_next = field_index + 3'd1;
          end
          char_in_field_next = 2'd0;
        end
        spu_pkg::TK_CHAR: begin
          if (char_in_field == 2'd0) begin
            case (field_index)
              spu_pkg::FLD_BAUD: begin
                if (head_tok.is_one) begin
                  baud_first_next = 1'b1;
                end else if (head_tok.baud1_ok) begin
                  baud_reg_next = head_tok.baud1_code;
                end else begin
                  error_flag_next = 1'b1;
                end
              end
              spu_pkg::FLD_DATA: begin
                if (head_tok.data_ok) begin
                  data_reg_next = head_tok.data_code;
                end else begin
                  error_flag_next = 1'b1;
                end
              end
              spu_pkg::FLD_PARITY: begin
                if (head_tok.par_ok) begin
                  parity_reg_next = head_tok.par_code;
                end else begin
                  error_flag_next = 1'b1;
                end
              end
              spu_pkg::FLD_STOP: begin
                stop_reg_next = !head_tok.is_one;
              end
              default: begin
              end
            endcase
          end else if (char_in_field == 2'd1 && field_index == spu_pkg::FLD_BAUD &&
                       baud_first) begin
            if (head_tok.baud2_ok) begin
              baud_reg_next = head_tok.baud2_code;
            end else begin
              error_flag_next = 1'b1;
            end
          end
          if (char_in_field < spu_pkg::CIF_MAX) begin
            char_in_field_next = char_in_field + 2'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Build the result from the updated state
  always_comb begin
    good                = !error_flag_next && (field_index_next >= spu_pkg::FLD_REST);
    result.ok           = good;
    result.baud_code    = good ? baud_reg_next : spu_pkg::BAUD_110;
    result.data_bits    = good ? spu_pkg::DATA_BASE + {2'b00, data_reg_next}
                               : spu_pkg::DATA_BASE;
    result.parity_code  = good ? parity_reg_next : spu_pkg::PAR_NONE;
    result.stop_bits    = (good && stop_reg_next) ? spu_pkg::STOP_TWO : spu_pkg::STOP_ONE;
    result.port_out     = head_tok.port;
  end

  // Commit state; clear it after the last byte
  always_ff @(posedge clk) begin
    if (rst || (pop && head_tok.last)) begin
      field_index   <= '0;
      char_in_field <= '0;
      baud_first    <= 1'b0;
      baud_reg      <= '0;
      data_reg      <= '0;
      parity_reg    <= '0;
      stop_reg      <= 1'b0;
      error_flag    <= 1'b0;
      string_ended  <= 1'b0;
    end else if (pop) begin
      field_index   <= field_index_next;
      char_in_field <= char_in_field_next;
      baud_first    <= baud_first_next;
      baud_reg      <= baud_reg_next;
      data_reg      <= data_reg_next;
      parity_reg    <= parity_reg_next;
      stop_reg      <= stop_reg_next;
      error_flag    <= error_flag_next;
      string_ended  <= string_ended_next;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && head_tok.last) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_tok.last) begin
      out_data <= result;
    end
  end

endmodule

[hdl/serial_mode_string_parser_unit.sv]
// Top level of the serial mode string parser.
//
//   channel   dir   payload                                             handshake
//   in_ch     in    char_in, port_num, last_char                        valid/ready
//   out_ch    out   ok, baud_code, data_bits, parity_code, stop_bits,   valid/ready
//                   port_out
//
// One byte is taken per cycle; the front end classifies it in the cycle it is
// taken and the back end applies one token per cycle out of a QUEUE_DEPTH queue.
// The result register loads at the edge where the last byte leaves the queue, so
// a result follows its last byte through a queue entry and then the result register.
// rst is synchronous and clears all parser state. A stalled output holds only
// last-byte tokens; other bytes drain, and input stalls only while the queue is full.
module serial_mode_string_parser_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  spu_chan_if.sink   in_ch,
  spu_chan_if.source out_ch
);

  logic              push;
  logic              full;
  logic              pop;
  logic              head_valid;
  spu_pkg::spu_tok_t push_tok;
  spu_pkg::spu_tok_t head_tok;

  spu_front u_front (
    .in_ch (in_ch),
    .full  (full),
    .push  (push),
    .tok   (push_tok)
  );

  spu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_tok   (push_tok),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_tok   (head_tok)
  );

  spu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_tok   (head_tok),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
